@@ rtl/core/stt_pkg.sv @@
package stt_pkg;

  localparam int SLOTS_DEFAULT = 32;
  localparam int TPM_W = 11;
  localparam int PERIOD_W = 31;
  localparam int OWNER_W = 24;
  localparam int PROD_W = PERIOD_W + TPM_W;

  localparam logic [TPM_W-1:0] TPM_RESET = 11'd32;
  localparam logic [PERIOD_W-1:0] NONE_ALARM = 31'h7fffffff;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TIMEUP = 2'd2;

  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_SAT = 2'd2;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [PERIOD_W-1:0] remaining;
  } slot_entry_t;

  typedef struct packed {
    logic kind;
    logic [7:0] client;
    logic [15:0] timer;
    logic [PERIOD_W-1:0] alarm_ticks;
    logic rearm;
    logic [1:0] error;
    logic last;
  } result_t;

endpackage

@@ rtl/core/stt_slot_ram.sv @@
module stt_slot_ram import stt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT,
  parameter int AW = $clog2(SLOTS)
) (
  input  logic        clk,
  input  logic [AW-1:0] rd_addr,
  output slot_entry_t rd_data,
  input  logic        wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_entry_t wr_data
);

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/stt_scale.sv @@
module stt_scale import stt_pkg::*; (
  input  logic                clk,
  input  logic                load,
  input  logic [PERIOD_W-1:0] period_ms,
  input  logic [TPM_W-1:0]    ticks_per_ms,
  output logic [PERIOD_W-1:0] scaled,
  output logic                sat
);

  logic [TPM_W-1:0] tpm_eff;
  logic [TPM_W-1:0] tpm;
  logic [PROD_W-1:0] product;
  logic [PROD_W:0] reach;

  // A zero register value scales as one tick per millisecond.
  assign tpm_eff = (ticks_per_ms == '0) ? TPM_W'(1) : ticks_per_ms;

  always_ff @(posedge clk) begin
    if (load) begin
      product <= PROD_W'(period_ms) * PROD_W'(tpm_eff);
      tpm <= tpm_eff;
    end
  end

  // period >= M / t (integer) holds exactly when (period + 1) * t > M.
  assign reach = {1'b0, product} + (PROD_W + 1)'(tpm);
  assign sat = reach > (PROD_W + 1)'(NONE_ALARM);
  assign scaled = (product > PROD_W'(NONE_ALARM)) ? NONE_ALARM : product[PERIOD_W-1:0];

endmodule

@@ rtl/core/stt_engine.sv @@
module stt_engine import stt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT,
  parameter int AW = $clog2(SLOTS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op,
  input  logic [7:0]          client,
  input  logic [15:0]         timer_num,
  input  logic [PERIOD_W-1:0] elapsed_ticks,
  input  logic [PERIOD_W-1:0] scaled,
  input  logic                sat,
  output logic [AW-1:0]       rd_addr,
  input  slot_entry_t         rd_data,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output slot_entry_t         wr_data,
  output logic                strobe,
  output result_t             res
);

  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [CW-1:0] cnt;
  logic proc_vld;
  logic [AW-1:0] proc_idx;
  logic [1:0] item_op;
  logic [OWNER_W-1:0] item_owner;
  logic [PERIOD_W-1:0] item_elapsed;
  logic [PERIOD_W-1:0] alarm;
  logic [AW-1:0] first_free;
  logic found;
  logic [SLOTS-1:0] valid;

  logic issue;
  logic slot_hit;
  logic owner_match;
  logic expired;
  logic [PERIOD_W-1:0] remain_left;
  logic do_clear;
  logic do_notice;
  logic do_charge;
  logic post_free;
  logic place;
  logic [PERIOD_W-1:0] final_alarm;
  logic [1:0] final_err;
  logic charging_op;

  assign busy = (state != ST_IDLE);
  assign issue = (state == ST_WALK) && (cnt < CW'(SLOTS));
  assign rd_addr = cnt[AW-1:0];

  // The slot read in the previous cycle is modified and written back this cycle.
  assign charging_op = (item_op == OP_START) || (item_op == OP_TIMEUP);
  assign slot_hit = proc_vld && valid[proc_idx];
  assign owner_match = ((item_op == OP_START) || (item_op == OP_CANCEL)) &&
                       (rd_data.owner == item_owner);
  assign expired = rd_data.remaining <= item_elapsed;
  assign remain_left = rd_data.remaining - item_elapsed;
  assign do_clear = slot_hit && (owner_match || (charging_op && expired));
  assign do_notice = slot_hit && !owner_match && charging_op && expired;
  assign do_charge = slot_hit && !owner_match && charging_op && !expired;
  assign post_free = proc_vld && (!valid[proc_idx] || do_clear);

  assign place = (item_op == OP_START) && (scaled != '0) && found;
  assign final_alarm = (place && (scaled < alarm)) ? scaled : alarm;

  always_comb begin
    final_err = ERR_OK;
    if (item_op == OP_START) begin
      if ((scaled != '0) && !found) begin
        final_err = ERR_FULL;
      end else if (sat) begin
        final_err = ERR_SAT;
      end
    end
  end

  always_comb begin
    if (state == ST_FINISH) begin
      wr_en = place;
      wr_addr = first_free;
      wr_data = '{owner: item_owner, remaining: scaled};
    end else begin
      wr_en = do_charge;
      wr_addr = proc_idx;
      wr_data = '{owner: rd_data.owner, remaining: remain_left};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      strobe <= 1'b0;
      proc_vld <= 1'b0;
      cnt <= '0;
      found <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            item_op <= op;
            item_owner <= {client, timer_num};
            item_elapsed <= elapsed_ticks;
            alarm <= NONE_ALARM;
            found <= 1'b0;
            cnt <= '0;
            proc_vld <= 1'b0;
            if ((op == OP_START) || (op == OP_CANCEL) || (op == OP_TIMEUP)) begin
              state <= ST_WALK;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_WALK: begin
          proc_vld <= issue;
          proc_idx <= rd_addr;
          if (issue) begin
            cnt <= cnt + CW'(1);
          end
          if (do_clear) begin
            valid[proc_idx] <= 1'b0;
          end
          if (do_charge && (remain_left < alarm)) begin
            alarm <= remain_left;
          end
          if (post_free && !found) begin
            found <= 1'b1;
            first_free <= proc_idx;
          end
          if (do_notice) begin
            strobe <= 1'b1;
            res <= '{kind: KIND_NOTICE, client: rd_data.owner[23:16],
                     timer: rd_data.owner[15:0], alarm_ticks: '0, rearm: 1'b0,
                     error: ERR_OK, last: 1'b0};
          end
          if (proc_vld && (proc_idx == AW'(SLOTS - 1))) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (place) begin
            valid[first_free] <= 1'b1;
          end
          strobe <= 1'b1;
          res <= '{kind: KIND_DONE, client: '0, timer: '0,
                   alarm_ticks: charging_op ? final_alarm : '0,
                   rearm: charging_op, error: final_err, last: 1'b1};
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/software_timer_table.sv @@
// Start, cancel and timeup walk every slot once, paced by the one-read-per-cycle slot
// memory; busy stays high through the walk. Expiry items leave at most one per cycle
// during the walk, and the done item comes last, as busy falls. Other op codes skip
// the walk and go straight to the finishing state.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Synchronous reset clears all slots and sets ticks_per_ms to 32.
module software_timer_table import stt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op,
  input  logic [7:0]          client,
  input  logic [15:0]         timer_num,
  input  logic [PERIOD_W-1:0] period_ms,
  input  logic [PERIOD_W-1:0] elapsed_ticks,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TPM_W-1:0]    cfg_data,
  output logic                strobe,
  output logic                kind,
  output logic [7:0]          expired_client,
  output logic [15:0]         expired_timer,
  output logic [PERIOD_W-1:0] alarm_ticks,
  output logic                rearm,
  output logic [1:0]          error,
  output logic                last
);

  localparam int AW = $clog2(SLOTS);

  logic [TPM_W-1:0] ticks_per_ms;
  logic [PERIOD_W-1:0] scaled;
  logic sat;
  logic [AW-1:0] rd_addr;
  slot_entry_t rd_data;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  slot_entry_t wr_data;
  result_t res;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= TPM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ticks_per_ms <= cfg_data;
    end
  end

  stt_scale u_scale (
    .clk          (clk),
    .load         (start && !busy),
    .period_ms    (period_ms),
    .ticks_per_ms (ticks_per_ms),
    .scaled       (scaled),
    .sat          (sat)
  );

  stt_slot_ram #(.SLOTS(SLOTS), .AW(AW)) u_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  stt_engine #(.SLOTS(SLOTS), .AW(AW)) u_engine (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .client        (client),
    .timer_num     (timer_num),
    .elapsed_ticks (elapsed_ticks),
    .scaled        (scaled),
    .sat           (sat),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .strobe        (strobe),
    .res           (res)
  );

  assign kind = res.kind;
  assign expired_client = res.client;
  assign expired_timer = res.timer;
  assign alarm_ticks = res.alarm_ticks;
  assign rearm = res.rearm;
  assign error = res.error;
  assign last = res.last;

  // Only the done item is final, and it is always of the done kind.
  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> kind == KIND_DONE)
    else $error("final item is not a done item");

  // Expiry items appear only while an operation is still in progress.
  a_notice_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("expiry item outside an operation");

  // An accepted operation always occupies the block in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !(strobe && last))
    else $error("operation finished without walking");

endmodule
